// ----- rtl/core/cfr_pkg.sv -----
// Shared types, codes and constants of the command frame responder.
package cfr_pkg;

	// Frame markers on the receive and transmit sides.
	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h55;
	localparam logic [7:0] RESP_A = 8'hCC;
	localparam logic [7:0] RESP_B = 8'h33;

	// Command codes that are answered.
	localparam logic [7:0] CMD_VERSION = 8'h01;
	localparam logic [7:0] CMD_CHANNEL = 8'h11;
	localparam logic [7:0] CMD_LINK    = 8'h12;
	localparam logic [7:0] CMD_INFO    = 8'h14;

	// Longest reply frame in bytes and the width of a byte count for it.
	localparam int FRAME_MAX = 9;
	localparam int CNT_W     = $clog2(FRAME_MAX + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUALITY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_OK  = 3'd5;

	// Register reset values.
	localparam logic [7:0] RST_VERSION  = 8'h0F;
	localparam logic [7:0] RST_SIGNAL_A = 8'd90;
	localparam logic [7:0] RST_SIGNAL_B = 8'd88;
	localparam logic [6:0] RST_QUALITY  = 7'd100;
	localparam logic [7:0] RST_STATUS   = 8'd0;
	localparam logic       RST_CHAN_OK  = 1'b1;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_CMD   = 3'd3,
		PH_SKIP  = 3'd4
	} phase_t;

	// Configuration values seen by the reply builder.
	typedef struct packed {
		logic [7:0] version_byte;
		logic [7:0] signal_a;
		logic [7:0] signal_b;
		logic [6:0] link_quality;
		logic [7:0] link_status;
		logic       channel_ok;
	} cfg_t;

	// Command request from the parser to the reply builder.
	typedef struct packed {
		logic       fire;
		logic [7:0] code;
	} cmd_t;

	typedef logic [7:0] frame_t [FRAME_MAX];

endpackage

// ----- rtl/core/cfr_parser.sv -----
// Receive-side frame parser: sync hunt, length, command pick-off and payload skip.
module cfr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output cfr_pkg::phase_t   phase,
	output cfr_pkg::cmd_t     cmd
);

	cfr_pkg::phase_t phase_q;
	cfr_pkg::phase_t phase_d;
	logic [7:0]      left_q;
	logic [7:0]      left_d;
	logic [7:0]      left_dec;

	assign phase    = phase_q;
	assign left_dec = left_q - 8'd1;

	// Phase and byte count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfr_pkg::PH_HUNT;
			left_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

	// Next phase for the byte on the input and the command strobe.
	always_comb begin
		phase_d  = cfr_pkg::PH_HUNT;
		left_d   = left_q;
		cmd.fire = 1'b0;
		cmd.code = rx_byte;
		unique case (phase_q)
			cfr_pkg::PH_SYNC2: begin
				phase_d = (rx_byte == cfr_pkg::SYNC_B) ? cfr_pkg::PH_LEN : cfr_pkg::PH_HUNT;
			end
			cfr_pkg::PH_LEN: begin
				left_d  = rx_byte;
				phase_d = (rx_byte != 8'd0) ? cfr_pkg::PH_CMD : cfr_pkg::PH_HUNT;
			end
			cfr_pkg::PH_CMD: begin
				cmd.fire = accept;
				left_d   = left_dec;
				phase_d  = (left_dec != 8'd0) ? cfr_pkg::PH_SKIP : cfr_pkg::PH_HUNT;
			end
			cfr_pkg::PH_SKIP: begin
				left_d  = left_dec;
				phase_d = (left_dec != 8'd0) ? cfr_pkg::PH_SKIP : cfr_pkg::PH_HUNT;
			end
			default: begin
				phase_d = (rx_byte == cfr_pkg::SYNC_A) ? cfr_pkg::PH_SYNC2 : cfr_pkg::PH_HUNT;
			end
		endcase
	end

endmodule

// ----- rtl/core/cfr_reply.sv -----
// Reply builder and byte serializer for the transmit channel.
module cfr_reply (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfr_pkg::cmd_t             cmd,
	input  cfr_pkg::cfg_t             cfg,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic                      last_going,
	output logic [7:0]                tx_byte,
	output logic                      reply_end
);

	cfr_pkg::frame_t          frame_q;
	cfr_pkg::frame_t          frame_d;
	logic [cfr_pkg::CNT_W-1:0] remain_q;
	logic [cfr_pkg::CNT_W-1:0] total_d;
	logic [9:0]               sum_w;
	logic                     out_take;

	assign out_valid  = (remain_q != '0);
	assign out_take   = out_valid && !out_stall;
	assign last_going = out_take && (remain_q == cfr_pkg::CNT_W'(1));
	assign tx_byte    = frame_q[0];
	assign reply_end  = (remain_q == cfr_pkg::CNT_W'(1));

	// Check byte of the link report wraps to eight bits.
	assign sum_w = 10'(cfg.signal_a) + 10'(cfg.signal_b)
		+ 10'(cfg.link_quality) + 10'(cfg.link_status);

	// Assemble the whole reply frame for the command.
	always_comb begin
		for (int i = 0; i < cfr_pkg::FRAME_MAX; i++) begin
			frame_d[i] = 8'd0;
		end
		frame_d[0] = cfr_pkg::RESP_A;
		frame_d[1] = cfr_pkg::RESP_B;
		frame_d[3] = cmd.code;
		total_d    = '0;
		unique case (cmd.code)
			cfr_pkg::CMD_VERSION: begin
				frame_d[2] = 8'd2;
				frame_d[4] = cfg.version_byte;
				total_d    = cfr_pkg::CNT_W'(5);
			end
			cfr_pkg::CMD_CHANNEL: begin
				frame_d[2] = 8'd2;
				frame_d[4] = {7'd0, cfg.channel_ok};
				total_d    = cfr_pkg::CNT_W'(5);
			end
			cfr_pkg::CMD_LINK: begin
				frame_d[2] = 8'd6;
				frame_d[4] = cfg.signal_a;
				frame_d[5] = cfg.signal_b;
				frame_d[6] = {1'b0, cfg.link_quality};
				frame_d[7] = cfg.link_status;
				frame_d[8] = sum_w[7:0];
				total_d    = cfr_pkg::CNT_W'(9);
			end
			cfr_pkg::CMD_INFO: begin
				frame_d[2] = 8'd5;
				frame_d[4] = 8'd1;
				frame_d[5] = 8'd1;
				frame_d[6] = 8'd1;
				frame_d[7] = 8'd3;
				total_d    = cfr_pkg::CNT_W'(8);
			end
			default: begin
				total_d = '0;
			end
		endcase
	end

	// Remaining byte count; a new reply only loads once the last one is going.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
		end else if (cmd.fire) begin
			remain_q <= total_d;
		end else if (out_take) begin
			remain_q <= remain_q - cfr_pkg::CNT_W'(1);
		end
	end

	// Frame shift register; the head byte is the one on the output.
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			frame_q <= frame_d;
		end else if (out_take) begin
			for (int i = 0; i < cfr_pkg::FRAME_MAX - 1; i++) begin
				frame_q[i] <= frame_q[i+1];
			end
		end
	end

endmodule

// ----- rtl/core/command_frame_responder.sv -----
// Top level of the command frame responder: config registers, parser and reply path.
//
// Receive channel: one byte per request on rx_byte, taken when in_valid is high and
// in_stall is low. Frames look like AA 55 LEN CMD payload; the parser hunts for the
// sync pair, reads LEN, picks off the command and skips the rest of the payload.
// Transmit channel: one reply byte per request on tx_byte, with reply_end marking the
// final byte, taken when out_valid is high and out_stall is low.
// Latency: the first reply byte is valid in the cycle after the command byte is taken.
// Throughput: one receive byte per cycle while in_stall is low; a reply goes out at one
// byte per cycle while out_stall is low, and is 5, 8 or 9 bytes long. The frame shift
// register holds one reply, so only a command byte arriving while a reply is still
// draining waits; sync, length and payload bytes are taken meanwhile.
// When the receiver stalls, tx_byte and reply_end hold, and in_stall rises as soon
// as the next command byte is due.
// Configuration: cfg_ready is always high; writes to indexes beyond the register list
// are dropped. Reset puts the parser in sync hunt, empties the reply path and loads
// the register defaults.
module command_frame_responder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    tx_byte,
	output logic                          reply_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	cfr_pkg::cfg_t   cfg_q;
	cfr_pkg::cmd_t   cmd;
	cfr_pkg::phase_t phase;
	logic            in_accept;
	logic            last_going;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	// Hold off a command byte until the reply path is free.
	assign in_stall = (phase == cfr_pkg::PH_CMD) && out_valid && !last_going;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_byte <= cfr_pkg::RST_VERSION;
			cfg_q.signal_a     <= cfr_pkg::RST_SIGNAL_A;
			cfg_q.signal_b     <= cfr_pkg::RST_SIGNAL_B;
			cfg_q.link_quality <= cfr_pkg::RST_QUALITY;
			cfg_q.link_status  <= cfr_pkg::RST_STATUS;
			cfg_q.channel_ok   <= cfr_pkg::RST_CHAN_OK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cfr_pkg::CFG_VERSION:  cfg_q.version_byte <= cfg_data;
				cfr_pkg::CFG_SIGNAL_A: cfg_q.signal_a     <= cfg_data;
				cfr_pkg::CFG_SIGNAL_B: cfg_q.signal_b     <= cfg_data;
				cfr_pkg::CFG_QUALITY:  cfg_q.link_quality <= cfg_data[6:0];
				cfr_pkg::CFG_STATUS:   cfg_q.link_status  <= cfg_data;
				cfr_pkg::CFG_CHAN_OK:  cfg_q.channel_ok   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	cfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.rx_byte (rx_byte),
		.phase   (phase),
		.cmd     (cmd)
	);

	cfr_reply u_reply (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.last_going (last_going),
		.tx_byte    (tx_byte),
		.reply_end  (reply_end)
	);

endmodule
